[hdl/mnep_pkg.sv]
// mnep_pkg: types, codes and helper functions for the midi note event parser
// used by mnep_parser and midi_note_event_parser, no dependencies
`default_nettype none

package mnep_pkg;

    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_SYS_TC      = 8'hF1;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] RT_FIRST       = 8'hF8;
    localparam logic [7:0] RT_STOP        = 8'hFC;
    localparam logic [7:0] RT_RESET       = 8'hFF;
    localparam logic [7:0] SX_ID_UNIV     = 8'h7F;
    localparam logic [7:0] SX_SUB_GEN     = 8'h06;
    localparam logic [7:0] SX_SUB_STOP    = 8'h01;
    localparam logic [7:0] CC_SOUND_OFF   = 8'd120;
    localparam logic [7:0] CC_NOTES_OFF   = 8'd123;
    localparam logic [3:0] CLS_NOTE_OFF   = 4'h8;
    localparam logic [3:0] CLS_NOTE_ON    = 4'h9;
    localparam logic [3:0] CLS_CTRL       = 4'hB;
    localparam logic [3:0] CLS_PROG       = 4'hC;
    localparam logic [3:0] CLS_PRESS      = 4'hD;
    localparam logic [3:0] CLS_SYSTEM     = 4'hF;
    localparam logic [2:0] SX_COUNT_FULL  = 3'd4;
    localparam logic signed [7:0] NOTE_ALL = -8'sd1;

    typedef enum logic [1:0] {
        KIND_NOTE_OFF = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_ALL_OFF  = 2'd2
    } mnep_kind_t;

    typedef struct packed {
        mnep_kind_t        kind;
        logic [7:0]        source;
        logic signed [7:0] note;
        logic [6:0]        velocity;
    } mnep_event_t;

    function automatic logic [1:0] data_len(input logic [7:0] st);
        logic [1:0] len;
        len = 2'd0;
        if (st[7]) begin
            if (st[7:4] != CLS_SYSTEM) begin
                len = (st[7:4] == CLS_PROG || st[7:4] == CLS_PRESS) ? 2'd1 : 2'd2;
            end else if (st == ST_SYS_TC || st == ST_SONG_SEL) begin
                len = 2'd1;
            end else if (st == ST_SONG_POS) begin
                len = 2'd2;
            end
        end
        return len;
    endfunction

    function automatic logic [6:0] sat7(input logic [7:0] v);
        return v[7] ? 7'h7F : v[6:0];
    endfunction

endpackage

`default_nettype wire

[hdl/mnep_parser.sv]
// mnep_parser: running status, open message and sysex window state with
// the event decode for one byte per cycle while byte_take is high, depends on mnep_pkg
`default_nettype none

module mnep_parser
    import mnep_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        byte_take,
    input  wire logic [7:0]  midi_byte,
    input  wire logic [7:0]  source_id,
    input  wire logic        packet_end,
    output logic             ev_valid,
    output mnep_event_t      ev
);

    logic [7:0] running_status_reg, running_status_next;
    logic [7:0] open_status_reg, open_status_next;
    logic [1:0] bytes_needed_reg, bytes_needed_next;
    logic [7:0] first_data_reg, first_data_next;
    logic       in_sysex_reg, in_sysex_next;
    logic [2:0] sysex_count_reg, sysex_count_next;
    logic       sysex_match_reg, sysex_match_next;

    mnep_event_t all_off;
    logic [3:0]  open_cls;

    assign all_off = '{kind: KIND_ALL_OFF, source: source_id, note: NOTE_ALL,
                       velocity: 7'd0};
    assign open_cls = open_status_reg[7:4];

    always_comb begin
        running_status_next = running_status_reg;
        open_status_next    = open_status_reg;
        bytes_needed_next   = bytes_needed_reg;
        first_data_next     = first_data_reg;
        in_sysex_next       = in_sysex_reg;
        sysex_count_next    = sysex_count_reg;
        sysex_match_next    = sysex_match_reg;
        ev_valid            = 1'b0;
        ev                  = all_off;

        if (in_sysex_reg) begin
            if (midi_byte != ST_SYSEX_END) begin
                if (sysex_count_reg < SX_COUNT_FULL) begin
                    if ((sysex_count_reg == 3'd0 && midi_byte != SX_ID_UNIV) ||
                        (sysex_count_reg == 3'd2 && midi_byte != SX_SUB_GEN) ||
                        (sysex_count_reg == 3'd3 && midi_byte != SX_SUB_STOP)) begin
                        sysex_match_next = 1'b0;
                    end
                    sysex_count_next = sysex_count_reg + 3'd1;
                end
            end
            if (midi_byte == ST_SYSEX_END || packet_end) begin
                ev_valid            = (sysex_count_next >= SX_COUNT_FULL) && sysex_match_next;
                in_sysex_next       = 1'b0;
                sysex_count_next    = 3'd0;
                sysex_match_next    = 1'b1;
                running_status_next = 8'd0;
            end
        end else if (bytes_needed_reg != 2'd0) begin
            if (bytes_needed_reg >= 2'd2) begin
                first_data_next   = midi_byte;
                bytes_needed_next = 2'd1;
            end else begin
                bytes_needed_next = 2'd0;
                open_status_next  = 8'd0;
                ev.note           = $signed({1'b0, sat7(first_data_reg)});
                if (open_cls == CLS_NOTE_ON) begin
                    ev_valid = 1'b1;
                    if (midi_byte == 8'd0) begin
                        ev.kind = KIND_NOTE_OFF;
                    end else begin
                        ev.kind     = KIND_NOTE_ON;
                        ev.velocity = sat7(midi_byte);
                    end
                end else if (open_cls == CLS_NOTE_OFF) begin
                    ev_valid = 1'b1;
                    ev.kind  = KIND_NOTE_OFF;
                end else if (open_cls == CLS_CTRL &&
                             (first_data_reg == CC_SOUND_OFF ||
                              first_data_reg == CC_NOTES_OFF)) begin
                    ev_valid = 1'b1;
                    ev       = all_off;
                end
            end
        end else if (midi_byte >= RT_FIRST) begin
            ev_valid = (midi_byte == RT_STOP) || (midi_byte == RT_RESET);
        end else if (midi_byte[7]) begin
            running_status_next = (midi_byte < ST_SYSEX_START) ? midi_byte : 8'd0;
            if (midi_byte == ST_SYSEX_START) begin
                in_sysex_next    = 1'b1;
                sysex_count_next = 3'd0;
                sysex_match_next = 1'b1;
            end else if (data_len(midi_byte) != 2'd0) begin
                open_status_next  = midi_byte;
                bytes_needed_next = data_len(midi_byte);
            end
        end else if (running_status_reg != 8'd0) begin
            if (data_len(running_status_reg) >= 2'd2) begin
                open_status_next  = running_status_reg;
                first_data_next   = midi_byte;
                bytes_needed_next = 2'd1;
            end
        end

        if (packet_end) begin
            running_status_next = 8'd0;
            open_status_next    = 8'd0;
            bytes_needed_next   = 2'd0;
            first_data_next     = 8'd0;
            in_sysex_next       = 1'b0;
            sysex_count_next    = 3'd0;
            sysex_match_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_status_reg <= 8'd0;
            open_status_reg    <= 8'd0;
            bytes_needed_reg   <= 2'd0;
            first_data_reg     <= 8'd0;
            in_sysex_reg       <= 1'b0;
            sysex_count_reg    <= 3'd0;
            sysex_match_reg    <= 1'b1;
        end else if (byte_take) begin
            running_status_reg <= running_status_next;
            open_status_reg    <= open_status_next;
            bytes_needed_reg   <= bytes_needed_next;
            first_data_reg     <= first_data_next;
            in_sysex_reg       <= in_sysex_next;
            sysex_count_reg    <= sysex_count_next;
            sysex_match_reg    <= sysex_match_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sysex_count_reg <= SX_COUNT_FULL)
        else $error("sysex count beyond saturation");

    a_sysex_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        in_sysex_reg |-> bytes_needed_reg == 2'd0)
        else $error("sysex open together with a channel message");

    a_packet_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_take && packet_end |=> !in_sysex_reg && bytes_needed_reg == 2'd0 &&
            running_status_reg == 8'd0)
        else $error("parse state not cleared after packet end");

endmodule

`default_nettype wire

[hdl/midi_note_event_parser.sv]
// midi_note_event_parser: top level with handshakes and a two-entry result buffer
// depends on mnep_pkg and mnep_parser
`default_nettype none

// Takes one MIDI byte per cycle while s_ready is high; each accepted byte updates
// the running-status and sysex state in the same cycle and any note-on, note-off or
// all-notes-off event it completes is registered in the output or skid register.
// Results sit in an output register backed by one skid entry, so a single
// stalled result never holds up the byte stream; s_ready only drops when both
// entries are full. Parse state clears after every byte marked packet_end.

module midi_note_event_parser
    import mnep_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_midi_byte,
    input  wire logic [7:0]         s_source_id,
    input  wire logic               s_packet_end,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_event_kind,
    output logic [7:0]              m_event_source,
    output logic signed [7:0]       m_note_number,
    output logic [6:0]              m_velocity_code
);

    logic        byte_take;
    logic        ev_valid;
    mnep_event_t ev;
    logic        push, pop;

    logic        out_valid_reg, skid_valid_reg;
    mnep_event_t out_reg, skid_reg;

    assign s_ready   = !skid_valid_reg;
    assign byte_take = s_valid && s_ready;
    assign push      = byte_take && ev_valid;
    assign pop       = out_valid_reg && m_ready;

    mnep_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_take  (byte_take),
        .midi_byte  (s_midi_byte),
        .source_id  (s_source_id),
        .packet_end (s_packet_end),
        .ev_valid   (ev_valid),
        .ev         (ev)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_reg <= skid_valid_reg ? skid_reg : ev;
        end else if (push) begin
            skid_reg <= ev;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_event_kind    = out_reg.kind;
    assign m_event_source  = out_reg.source;
    assign m_note_number   = out_reg.note;
    assign m_velocity_code = out_reg.velocity;

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_all_off_note: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == KIND_ALL_OFF |-> m_note_number == NOTE_ALL &&
            m_velocity_code == 7'd0)
        else $error("all notes off with note or velocity set");

    a_note_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != KIND_ALL_OFF |-> !m_note_number[7])
        else $error("note event with negative note number");

    a_off_velocity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != KIND_NOTE_ON |-> m_velocity_code == 7'd0)
        else $error("note off carrying velocity");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_valid)
        else $error("transfer with result left no result pending");

endmodule

`default_nettype wire

[test/mnep_event_checker.sv]
// mnep_event_checker: watches both channels of the midi note event parser, predicts the
// note events from the accepted bytes and compares every result transfer field by field
// depends on mnep_pkg for the event struct, kinds and status codes
module mnep_event_checker
    import mnep_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [7:0]        s_midi_byte,
    input  logic [7:0]        s_source_id,
    input  logic              s_packet_end,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [1:0]        m_event_kind,
    input  logic [7:0]        m_event_source,
    input  logic signed [7:0] m_note_number,
    input  logic [6:0]        m_velocity_code,
    output int                fail_count,
    output int                events_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // parse state
    logic [7:0] run_status;
    logic [7:0] open_stat;
    logic [1:0] data_left;
    logic [7:0] held_data;
    logic       in_sx;
    logic [2:0] sx_count;
    logic       sx_match;

    mnep_event_t events_due[$];
    int          mismatch_tally = 0;

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_tally++;
    endtask

    function automatic int unsigned payload_len(input logic [7:0] st);
        if (!st[7]) return 0;
        if (st[7:4] != CLS_SYSTEM) return (st[7:4] == CLS_PROG || st[7:4] == CLS_PRESS) ? 1 : 2;
        if (st == ST_SYS_TC || st == ST_SONG_SEL) return 1;
        if (st == ST_SONG_POS) return 2;
        return 0;
    endfunction

    function automatic logic [6:0] clamp7(input logic [7:0] v);
        return (v > 8'd127) ? 7'd127 : v[6:0];
    endfunction

    function automatic void clear_parse();
        run_status = 8'h00;
        open_stat  = 8'h00;
        data_left  = 2'd0;
        held_data  = 8'h00;
        in_sx      = 1'b0;
        sx_count   = 3'd0;
        sx_match   = 1'b1;
    endfunction

    function automatic logic sx_close();
        logic hit;
        hit        = (sx_count >= SX_COUNT_FULL) && sx_match;
        in_sx      = 1'b0;
        sx_count   = 3'd0;
        sx_match   = 1'b1;
        run_status = 8'h00;
        return hit;
    endfunction

    // completes a channel message; ev already holds an all-notes-off with the source
    function automatic logic finish_msg(input logic [7:0] st, input logic [7:0] d1,
                                        input logic [7:0] d2, inout mnep_event_t ev);
        case (st[7:4])
            CLS_NOTE_ON: begin
                ev.kind     = (d2 == 8'h00) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                ev.note     = {1'b0, clamp7(d1)};
                ev.velocity = (d2 == 8'h00) ? 7'd0 : clamp7(d2);
                return 1'b1;
            end
            CLS_NOTE_OFF: begin
                ev.kind     = KIND_NOTE_OFF;
                ev.note     = {1'b0, clamp7(d1)};
                ev.velocity = 7'd0;
                return 1'b1;
            end
            CLS_CTRL: begin
                return (d1 == CC_SOUND_OFF || d1 == CC_NOTES_OFF);
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic logic parse_byte(input logic [7:0] b, input logic [7:0] src,
                                        input logic pkt_last, output mnep_event_t ev);
        logic hit;
        hit = 1'b0;
        ev.kind     = KIND_ALL_OFF;
        ev.source   = src;
        ev.note     = NOTE_ALL;
        ev.velocity = 7'd0;
        if (in_sx) begin
            if (b == ST_SYSEX_END) begin
                hit = sx_close();
            end else begin
                if (sx_count < SX_COUNT_FULL) begin
                    if ((sx_count == 3'd0 && b != SX_ID_UNIV) ||
                        (sx_count == 3'd2 && b != SX_SUB_GEN) ||
                        (sx_count == 3'd3 && b != SX_SUB_STOP))
                        sx_match = 1'b0;
                    sx_count = sx_count + 3'd1;
                end
                if (pkt_last) hit = sx_close();
            end
        end else if (data_left != 2'd0) begin
            if (data_left == 2'd2) begin
                held_data = b;
                data_left = 2'd1;
            end else begin
                hit       = finish_msg(open_stat, held_data, b, ev);
                data_left = 2'd0;
                open_stat = 8'h00;
            end
        end else if (b >= RT_FIRST) begin
            hit = (b == RT_STOP || b == RT_RESET);
        end else if (b[7]) begin
            run_status = (b[7:4] != CLS_SYSTEM) ? b : 8'h00;
            if (b == ST_SYSEX_START) begin
                in_sx    = 1'b1;
                sx_count = 3'd0;
                sx_match = 1'b1;
            end else if (payload_len(b) != 0) begin
                open_stat = b;
                data_left = 2'(payload_len(b));
            end
        end else if (run_status != 8'h00) begin
            if (payload_len(run_status) == 2) begin
                open_stat = run_status;
                held_data = b;
                data_left = 2'd1;
            end
        end
        if (pkt_last) clear_parse();
        return hit;
    endfunction

    always @(posedge aclk) begin
        mnep_event_t ev;
        mnep_event_t want;
        if (!aresetn) begin
            clear_parse();
            events_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (events_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected event kind %0d source %0d note %0d",
                                            m_event_kind, m_event_source, m_note_number));
                end else begin
                    want = events_due.pop_front();
                    if (m_event_kind != want.kind)
                        flag_mismatch($sformatf("kind %0d, expected %0d",
                                                m_event_kind, want.kind));
                    if (m_event_source != want.source)
                        flag_mismatch($sformatf("source %0d, expected %0d",
                                                m_event_source, want.source));
                    if (m_note_number != want.note)
                        flag_mismatch($sformatf("note %0d, expected %0d",
                                                m_note_number, want.note));
                    if (m_velocity_code != want.velocity)
                        flag_mismatch($sformatf("velocity %0d, expected %0d",
                                                m_velocity_code, want.velocity));
                end
            end
            if (s_valid && s_ready) begin
                if (parse_byte(s_midi_byte, s_source_id, s_packet_end, ev))
                    events_due.insert(events_due.size(), ev);
            end
        end
        events_pending <= events_due.size();
        fail_count     <= mismatch_tally;
    end

endmodule

[test/tb_top.sv]
// tb_top: byte stimulus, handshake idling and verdict for midi_note_event_parser
// depends on mnep_pkg, midi_note_event_parser and mnep_event_checker
module tb_top
    import mnep_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 660;

    typedef enum int {
        MSG_NOTE_ON, MSG_NOTE_OFF, MSG_RUNNING, MSG_CTRL, MSG_SHORT, MSG_BEND,
        MSG_SYSTEM, MSG_REALTIME, MSG_SYSEX, MSG_STRAY, MSG_NOISE
    } msg_shape_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_midi_byte = 8'h00;
    logic [7:0]        s_source_id = 8'h00;
    logic              s_packet_end = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_event_kind;
    logic [7:0]        m_event_source;
    logic signed [7:0] m_note_number;
    logic [6:0]        m_velocity_code;

    int          fail_count;
    int          events_pending;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int unsigned send_idle_pct = 19;
    int unsigned recv_idle_pct = 53;
    logic [7:0]  pkt_bytes[$];

    always #5 aclk = ~aclk;

    midi_note_event_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_midi_byte    (s_midi_byte),
        .s_source_id    (s_source_id),
        .s_packet_end   (s_packet_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_event_source (m_event_source),
        .m_note_number  (m_note_number),
        .m_velocity_code(m_velocity_code)
    );

    mnep_event_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_midi_byte    (s_midi_byte),
        .s_source_id    (s_source_id),
        .s_packet_end   (s_packet_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_event_source (m_event_source),
        .m_note_number  (m_note_number),
        .m_velocity_code(m_velocity_code),
        .fail_count     (fail_count),
        .events_pending (events_pending)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [7:0] src, input logic pkt_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid      <= 1'b0;
            s_midi_byte  <= 8'($urandom);
            s_packet_end <= 1'($urandom);
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_midi_byte  <= b;
        s_source_id  <= src;
        s_packet_end <= pkt_end;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_burst(input logic [7:0] burst[$], input logic [7:0] src,
                              input logic pkt_end);
        foreach (burst[i])
            send_byte(burst[i], src, pkt_end && (i == burst.size() - 1));
    endtask

    function automatic void add_byte(input logic [7:0] b);
        pkt_bytes.insert(pkt_bytes.size(), b);
    endfunction

    // mostly proper data bytes, now and then one with the top bit set
    function automatic logic [7:0] rand_data();
        if ($urandom_range(15) == 0) return 8'($urandom);
        return 8'($urandom_range(127));
    endfunction

    task automatic add_message();
        msg_shape_t shape;
        logic [7:0] chan;
        int         extra;
        shape = msg_shape_t'($urandom_range(MSG_NOISE));
        chan  = 8'($urandom_range(15));
        case (shape)
            MSG_NOTE_ON: begin
                add_byte({CLS_NOTE_ON, chan[3:0]});
                add_byte(rand_data());
                add_byte(($urandom_range(4) == 0) ? 8'h00 : rand_data());
            end
            MSG_NOTE_OFF: begin
                add_byte({CLS_NOTE_OFF, chan[3:0]});
                add_byte(rand_data());
                add_byte(rand_data());
            end
            MSG_RUNNING: begin
                add_byte(8'($urandom_range(127)));
                add_byte(($urandom_range(3) == 0) ? 8'h00 : rand_data());
            end
            MSG_CTRL: begin
                add_byte({CLS_CTRL, chan[3:0]});
                case ($urandom_range(2))
                    0: add_byte(CC_SOUND_OFF);
                    1: add_byte(CC_NOTES_OFF);
                    default: add_byte(rand_data());
                endcase
                add_byte(rand_data());
            end
            MSG_SHORT: begin
                add_byte({($urandom_range(1) == 0) ? CLS_PROG : CLS_PRESS, chan[3:0]});
                add_byte(rand_data());
            end
            MSG_BEND: begin
                add_byte({4'hE, chan[3:0]});
                add_byte(rand_data());
                add_byte(rand_data());
            end
            MSG_SYSTEM: begin
                case ($urandom_range(3))
                    0: begin
                        add_byte(ST_SYS_TC);
                        add_byte(rand_data());
                    end
                    1: begin
                        add_byte(ST_SONG_SEL);
                        add_byte(rand_data());
                    end
                    2: begin
                        add_byte(ST_SONG_POS);
                        add_byte(rand_data());
                        add_byte(rand_data());
                    end
                    default: add_byte(8'(8'hF4 + $urandom_range(3)));
                endcase
            end
            MSG_REALTIME: begin
                add_byte(8'(RT_FIRST + $urandom_range(7)));
            end
            MSG_SYSEX: begin
                add_byte(ST_SYSEX_START);
                add_byte(($urandom_range(4) != 0) ? SX_ID_UNIV : rand_data());
                add_byte(rand_data());
                add_byte(($urandom_range(4) != 0) ? SX_SUB_GEN : rand_data());
                add_byte(($urandom_range(4) != 0) ? SX_SUB_STOP : rand_data());
                extra = $urandom_range(2);
                repeat (extra) add_byte(($urandom_range(3) == 0) ?
                                        8'($urandom) : rand_data());
                if ($urandom_range(4) != 0) add_byte(ST_SYSEX_END);
            end
            MSG_STRAY: begin
                add_byte(8'($urandom_range(127)));
            end
            default: begin
                add_byte(8'($urandom));
            end
        endcase
    endtask

    task automatic send_random_packet();
        int         n_msgs;
        logic [7:0] src;
        n_msgs = $urandom_range(1, 5);
        src    = 8'($urandom);
        pkt_bytes.delete();
        repeat (n_msgs) add_message();
        // cut the packet short so an unfinished message gets dropped
        if ($urandom_range(7) == 0 && pkt_bytes.size() > 1) void'(pkt_bytes.pop_back());
        send_burst(pkt_bytes, src, 1'b1);
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = bytes_sent + ITEMS_PER_PHASE;
        while (bytes_sent < stop_at) send_random_packet();
    endtask

    initial begin
        logic [7:0] burst[$];
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: note on, running status with zero velocity, saturated data,
        // controller all-off, stop and reset, sysex all-off closed by F7 and by packet end
        burst = '{8'h90, 8'h3C, 8'h64};
        send_burst(burst, 8'h00, 1'b0);
        burst = '{8'h3C, 8'h00};
        send_burst(burst, 8'hFF, 1'b0);
        burst = '{8'h80, 8'hFF, 8'h80};
        send_burst(burst, 8'h00, 1'b0);
        burst = '{8'hB0, CC_NOTES_OFF, 8'h00};
        send_burst(burst, 8'hFF, 1'b0);
        burst = '{RT_STOP, RT_RESET};
        send_burst(burst, 8'h00, 1'b0);
        burst = '{ST_SYSEX_START, SX_ID_UNIV, 8'h12, SX_SUB_GEN, SX_SUB_STOP, ST_SYSEX_END};
        send_burst(burst, 8'hFF, 1'b0);
        burst = '{8'h9F, 8'h40, 8'hFF};
        send_burst(burst, 8'hA5, 1'b1);
        burst = '{ST_SYSEX_START, SX_ID_UNIV, 8'h00, SX_SUB_GEN, SX_SUB_STOP};
        send_burst(burst, 8'h5A, 1'b1);

        run_phase(19, 53);
        run_phase(53, 19);
        run_phase(0, 0);

        s_valid <= 1'b0;
        while (events_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fail_count == 0 && events_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
